@@ design/lcr_pkg.sv @@
// ----------------------------------------------------------------------------
// Line command receiver package
// Beat types, function and result codes, and the command word table.
// ----------------------------------------------------------------------------
package lcr_pkg;

   localparam logic [1:0] FUNC_BYTE  = 2'd0;
   localparam logic [1:0] FUNC_POLL  = 2'd1;
   localparam logic [1:0] FUNC_ERROR = 2'd2;

   localparam logic [1:0] KIND_TOO_LONG = 2'd0;
   localparam logic [1:0] KIND_STATUS   = 2'd1;
   localparam logic [1:0] KIND_UNKNOWN  = 2'd2;

   localparam logic [7:0] CHAR_CR   = 8'h0D;
   localparam logic [7:0] CHAR_LF   = 8'h0A;
   localparam logic [7:0] CHAR_NULL = 8'h00;

   localparam int WORD_LEN = 6;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] rx_byte;
      logic       place_a_occupied;
      logic       place_b_occupied;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic       place_a_used;
      logic       place_b_used;
      logic       last;
   } rsp_type;

   // Characters of the STATUS command word.
   function automatic logic [7:0] status_char(input logic [2:0] idx);
      logic [7:0] c;
      case (idx)
         3'd0: c = 8'h53;
         3'd1: c = 8'h54;
         3'd2: c = 8'h41;
         3'd3: c = 8'h54;
         3'd4: c = 8'h55;
         3'd5: c = 8'h53;
         default: c = CHAR_NULL;
      endcase
      return c;
   endfunction

endpackage

@@ design/lcr_channels.sv @@
// ----------------------------------------------------------------------------
// Line command receiver channels
// Valid/ready channels for request beats and response beats.
// ----------------------------------------------------------------------------
interface lcr_req_if import lcr_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lcr_rsp_if import lcr_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ design/line_command_receiver_unit.sv @@
// ----------------------------------------------------------------------------
// Line command receiver
// Collects received bytes into lines and answers polls with command results.
// ----------------------------------------------------------------------------
// One request beat is taken in every cycle while the four-entry response
// buffer has room for two results, and each beat is fully handled in the
// cycle it is taken. A poll beat places its zero, one or two results into
// the buffer at that edge, and it drains one result per cycle while the
// sink is ready. Since a poll is the only beat that yields results, the
// response side sets the sustained rate only when the sink stalls. The
// line text is not kept as such: as bytes arrive, the first characters
// are compared with the STATUS word, and the verdict is latched when the
// line ends, which gives the same answer as matching the stored line.
module line_command_receiver_unit
   import lcr_pkg::*;
#(
   parameter int LINE_BYTES = 16
) (
   input  logic      clock,
   input  logic      reset,
   lcr_req_if.sink   req_port,
   lcr_rsp_if.source rsp_port
);

   localparam int LEN_W = $clog2(LINE_BYTES);

   logic [LEN_W-1:0]     line_length_ff, line_length_in;
   logic                 line_ready_ff, line_ready_in;
   logic                 overflow_pending_ff, overflow_pending_in;
   logic                 prefix_ok_ff, prefix_ok_in;
   logic                 word_hit_ff, word_hit_in;
   logic                 cmd_status_ff, cmd_status_in;

   rsp_type              rsp_mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;

   req_type              req;
   logic                 req_take;
   logic                 rsp_take;
   logic                 is_term;
   logic                 push_first;
   logic                 push_second;
   rsp_type              first_rsp;
   rsp_type              cmd_rsp;
   logic [RSP_CNT_W-1:0] push_count;

   assign req            = req_port.payload;
   assign req_port.ready = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign req_take       = req_port.valid && req_port.ready;
   assign rsp_take       = rsp_port.valid && rsp_port.ready;
   assign is_term        = (req.rx_byte == CHAR_CR) || (req.rx_byte == CHAR_LF);

   always_comb begin
      line_length_in      = line_length_ff;
      line_ready_in       = line_ready_ff;
      overflow_pending_in = overflow_pending_ff;
      prefix_ok_in        = prefix_ok_ff;
      word_hit_in         = word_hit_ff;
      cmd_status_in       = cmd_status_ff;
      if (req_take) begin
         case (req.func)
            FUNC_BYTE: begin
               if (is_term) begin
                  if ((line_length_ff != '0) && !line_ready_ff) begin
                     line_ready_in = 1'b1;
                     cmd_status_in =
                        ((line_length_ff == LEN_W'(WORD_LEN)) && prefix_ok_ff) ||
                        ((line_length_ff > LEN_W'(WORD_LEN)) && word_hit_ff);
                  end
                  line_length_in = '0;
               end else if (!line_ready_ff) begin
                  if (line_length_ff < LEN_W'(LINE_BYTES - 1)) begin
                     if (line_length_ff < LEN_W'(WORD_LEN)) begin
                        prefix_ok_in = ((line_length_ff == '0) || prefix_ok_ff) &&
                           (req.rx_byte == status_char(line_length_ff[2:0]));
                     end
                     if (line_length_ff == LEN_W'(WORD_LEN)) begin
                        word_hit_in = prefix_ok_ff && (req.rx_byte == CHAR_NULL);
                     end
                     line_length_in = line_length_ff + LEN_W'(1);
                  end else begin
                     line_length_in      = '0;
                     overflow_pending_in = 1'b1;
                  end
               end
            end
            FUNC_POLL: begin
               line_ready_in       = 1'b0;
               overflow_pending_in = 1'b0;
            end
            FUNC_ERROR: begin
               line_length_in = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      if (cmd_status_ff) begin
         cmd_rsp = '{kind: KIND_STATUS, place_a_used: req.place_a_occupied,
                     place_b_used: req.place_b_occupied, last: 1'b1};
      end else begin
         cmd_rsp = '{kind: KIND_UNKNOWN, place_a_used: 1'b0,
                     place_b_used: 1'b0, last: 1'b1};
      end
      if (overflow_pending_ff) begin
         first_rsp = '{kind: KIND_TOO_LONG, place_a_used: 1'b0,
                       place_b_used: 1'b0, last: !line_ready_ff};
      end else begin
         first_rsp = cmd_rsp;
      end
      push_first  = req_take && (req.func == FUNC_POLL) &&
                    (overflow_pending_ff || line_ready_ff);
      push_second = req_take && (req.func == FUNC_POLL) &&
                    overflow_pending_ff && line_ready_ff;
      push_count  = RSP_CNT_W'(push_first) + RSP_CNT_W'(push_second);
      wr_ptr_in   = wr_ptr_ff + RSP_PTR_W'(push_count);
      rd_ptr_in   = rd_ptr_ff + RSP_PTR_W'(rsp_take);
      count_in    = count_ff + push_count - RSP_CNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff      <= '0;
         line_ready_ff       <= 1'b0;
         overflow_pending_ff <= 1'b0;
         rd_ptr_ff           <= '0;
         wr_ptr_ff           <= '0;
         count_ff            <= '0;
      end else begin
         line_length_ff      <= line_length_in;
         line_ready_ff       <= line_ready_in;
         overflow_pending_ff <= overflow_pending_in;
         rd_ptr_ff           <= rd_ptr_in;
         wr_ptr_ff           <= wr_ptr_in;
         count_ff            <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      prefix_ok_ff  <= prefix_ok_in;
      word_hit_ff   <= word_hit_in;
      cmd_status_ff <= cmd_status_in;
      if (push_first) begin
         rsp_mem_ff[wr_ptr_ff] <= first_rsp;
      end
      if (push_second) begin
         rsp_mem_ff[wr_ptr_ff + RSP_PTR_W'(1)] <= cmd_rsp;
      end
   end

   assign rsp_port.valid   = (count_ff != '0);
   assign rsp_port.payload = rsp_mem_ff[rd_ptr_ff];

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_W'(RSP_DEPTH))
      else $error("Response buffer count exceeds its depth.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_port.valid && (rsp_port.payload.kind != KIND_TOO_LONG) |-> rsp_port.payload.last)
      else $error("Command result beat is not marked last.");

   assert property (@(posedge clock) disable iff (reset)
      req_take && (req.func == FUNC_POLL) |=> !line_ready_ff && !overflow_pending_ff)
      else $error("Poll did not consume the pending line and overflow.");

   assert property (@(posedge clock) disable iff (reset)
      line_ready_ff && req_take && (req.func == FUNC_BYTE) && !is_term
      |=> $stable(line_length_ff))
      else $error("Line length moved while a line was ready.");

endmodule

@@ verif/line_command_receiver_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Line command receiver testbench
// A short table of directed beats walks the line, overflow, error and poll
// paths, then constrained-by-hand random sessions of lines and polls run
// with random gaps and stalls on both channels. Every response beat is
// checked against fixed row replies or a cycle-free line store and flag model.
// ----------------------------------------------------------------------------
module line_command_receiver_unit_tb import lcr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          LINE_BYTES  = 16;
   localparam int          MAX_GAP     = 9;
   localparam int          NUM_BEATS   = 750;
   localparam logic [1:0]  FUNC_UNUSED = 2'd3;
   localparam logic [47:0] CMD_WORD    = "STATUS";
   localparam rsp_type     NO_RSP      = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #5 clock = ~clock;

   lcr_req_if req_ch ();
   lcr_rsp_if rsp_ch ();

   line_command_receiver_unit #(.LINE_BYTES(LINE_BYTES)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   logic [7:0] line_buf [LINE_BYTES];
   int         line_len = 0;
   bit         line_held = 1'b0;
   bit         too_long_seen = 1'b0;
   rsp_type    replies_due [$];
   int         mismatches = 0;
   int         beats_sent = 0;
   bit         tx_calm = 1'b0;

   typedef struct {
      logic [1:0] func;
      string      text;
      logic [7:0] rx;
      int         reps;
      logic       pa;
      logic       pb;
      int         fixed_n;
      rsp_type    r0;
      rsp_type    r1;
   } script_row_type;

   // A fixed_n of -1 means the replies come from the model.
   script_row_type directed_rows [25] = '{
      '{FUNC_POLL,   "",       8'h00,     1,  1'b1, 1'b1, 0,  NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "",       CHAR_CR,   1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "STATUS", 8'h00,     1,  1'b0, 1'b1, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "",       CHAR_LF,   1,  1'b1, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "Q",      8'h00,     1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "",       CHAR_CR,   1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_POLL,   "",       8'h00,     1,  1'b1, 1'b0, 1,
        rsp_type'{KIND_STATUS, 1'b1, 1'b0, 1'b1}, NO_RSP},
      '{FUNC_BYTE,   "",       8'hFF,     16, 1'b1, 1'b1, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "A",      8'h00,     1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "",       CHAR_CR,   1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_POLL,   "",       8'h00,     1,  1'b1, 1'b1, 2,
        rsp_type'{KIND_TOO_LONG, 1'b0, 1'b0, 1'b0},
        rsp_type'{KIND_UNKNOWN, 1'b0, 1'b0, 1'b1}},
      '{FUNC_BYTE,   "STATUS", 8'h00,     1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "",       CHAR_NULL, 1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "X",      8'h00,     1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "",       CHAR_LF,   1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_POLL,   "",       8'h00,     1,  1'b0, 1'b1, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "STAT",   8'h00,     1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_ERROR,  "",       8'hFF,     1,  1'b1, 1'b1, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "STATU",  8'h00,     1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_BYTE,   "",       CHAR_CR,   1,  1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_POLL,   "",       8'h00,     1,  1'b1, 1'b1, 1,
        rsp_type'{KIND_UNKNOWN, 1'b0, 1'b0, 1'b1}, NO_RSP},
      '{FUNC_BYTE,   "",       8'h7F,     16, 1'b0, 1'b0, -1, NO_RSP, NO_RSP},
      '{FUNC_POLL,   "",       8'h00,     1,  1'b0, 1'b0, 1,
        rsp_type'{KIND_TOO_LONG, 1'b0, 1'b0, 1'b1}, NO_RSP},
      '{FUNC_UNUSED, "",       8'hFF,     1,  1'b1, 1'b1, -1, NO_RSP, NO_RSP},
      '{FUNC_POLL,   "",       8'h00,     1,  1'b1, 1'b1, -1, NO_RSP, NO_RSP}
   };

   function automatic bit held_line_is_status();
      for (int i = 0; i < 6; i++)
         if (line_buf[i] != CMD_WORD[47 - 8 * i -: 8])
            return 1'b0;
      return line_buf[6] == CHAR_NULL;
   endfunction

   function automatic void predict_replies(input req_type b, input bit keep);
      bit cmd;
      bit ovf;
      case (b.func)
         FUNC_BYTE: begin
            if (b.rx_byte == CHAR_CR || b.rx_byte == CHAR_LF) begin
               if (line_len > 0 && !line_held) begin
                  line_buf[line_len] = CHAR_NULL;
                  line_held = 1'b1;
               end
               line_len = 0;
            end else if (!line_held) begin
               if (line_len < LINE_BYTES - 1) begin
                  line_buf[line_len] = b.rx_byte;
                  line_len++;
               end else begin
                  line_len = 0;
                  too_long_seen = 1'b1;
               end
            end
         end
         FUNC_POLL: begin
            cmd = line_held;
            ovf = too_long_seen;
            line_held = 1'b0;
            too_long_seen = 1'b0;
            if (keep && ovf)
               replies_due.push_back(rsp_type'{KIND_TOO_LONG, 1'b0, 1'b0, ~cmd});
            if (keep && cmd) begin
               if (held_line_is_status())
                  replies_due.push_back(rsp_type'{KIND_STATUS, b.place_a_occupied,
                                                  b.place_b_occupied, 1'b1});
               else
                  replies_due.push_back(rsp_type'{KIND_UNKNOWN, 1'b0, 1'b0, 1'b1});
            end
         end
         FUNC_ERROR: begin
            line_len = 0;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_beat(input req_type b, input bit keep);
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= b;
      do @(posedge clock); while (!req_ch.ready);
      predict_replies(b, keep);
      if (b.func != FUNC_UNUSED)
         beats_sent++;
   endtask

   task automatic send_char(input logic [7:0] c);
      send_beat('{FUNC_BYTE, c, 1'($urandom), 1'($urandom)}, 1'b1);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] c;
      do c = 8'($urandom); while (c == CHAR_CR || c == CHAR_LF);
      return c;
   endfunction

   task automatic drain_replies();
      if (replies_due.size() != 0) begin
         req_ch.valid <= 1'b0;
         while (replies_due.size() != 0)
            @(posedge clock);
      end
   endtask

   task automatic line_exchange();
      int         style;
      int         n;
      int         flip;
      logic [7:0] c;
      style = $urandom_range(0, 9);
      case (style)
         0, 1, 2: send_text("STATUS");
         3: begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++)
               send_char(CMD_WORD[47 - 8 * i -: 8]);
         end
         4: begin
            send_text("STATUS");
            repeat ($urandom_range(1, 3)) send_char(plain_char());
         end
         5: begin
            send_text("STATUS");
            send_char(CHAR_NULL);
            repeat ($urandom_range(0, 5)) send_char(plain_char());
         end
         6: repeat ($urandom_range(1, 8)) send_char(plain_char());
         7: repeat ($urandom_range(14, 20)) send_char(plain_char());
         8: begin
            repeat ($urandom_range(1, 6)) send_char(plain_char());
            send_beat('{FUNC_ERROR, 8'($urandom), 1'($urandom), 1'($urandom)}, 1'b1);
            send_text("STATUS");
         end
         default: begin
            flip = $urandom_range(0, 5);
            for (int i = 0; i < 6; i++) begin
               c = CMD_WORD[47 - 8 * i -: 8];
               if (i == flip)
                  c = c ^ (8'd1 << $urandom_range(0, 7));
               send_char(c);
            end
         end
      endcase
      send_char($urandom_range(0, 1) ? CHAR_CR : CHAR_LF);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3))
            send_char($urandom_range(0, 1) ? plain_char() : CHAR_LF);
      if ($urandom_range(0, 4) != 0)
         send_beat('{FUNC_POLL, 8'($urandom), 1'($urandom), 1'($urandom)}, 1'b1);
   endtask

   initial begin : stimulus
      bit from_model;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      for (int i = 0; i < LINE_BYTES; i++)
         line_buf[i] = CHAR_NULL;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         from_model = directed_rows[r].fixed_n < 0;
         for (int k = 0; k < directed_rows[r].reps; k++) begin
            if (directed_rows[r].func == FUNC_BYTE && directed_rows[r].text.len() > 0) begin
               for (int i = 0; i < directed_rows[r].text.len(); i++)
                  send_beat('{FUNC_BYTE, directed_rows[r].text[i], directed_rows[r].pa,
                              directed_rows[r].pb}, from_model);
            end else begin
               send_beat('{directed_rows[r].func, directed_rows[r].rx, directed_rows[r].pa,
                           directed_rows[r].pb}, from_model);
            end
         end
         if (directed_rows[r].fixed_n >= 1)
            replies_due.push_back(directed_rows[r].r0);
         if (directed_rows[r].fixed_n >= 2)
            replies_due.push_back(directed_rows[r].r1);
      end
      drain_replies();

      while (beats_sent < NUM_BEATS) begin
         tx_calm = ($urandom_range(0, 5) == 0);
         if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 6))
               send_beat('{2'($urandom), 8'($urandom), 1'($urandom), 1'($urandom)}, 1'b1);
         end else begin
            line_exchange();
         end
         if ($urandom_range(0, 39) == 0)
            drain_replies();
      end

      req_ch.valid <= 1'b0;
      while (replies_due.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatches == 0)
         $display("line_command_receiver_unit: match");
      else
         $display("line_command_receiver_unit: mismatch");
      $finish;
   end

   initial begin : reply_check
      rsp_type want;
      rsp_type got;
      int      stall;
      int      calm_left;
      bit      rx_calm;
      rsp_ch.ready = 1'b0;
      calm_left = 0;
      rx_calm = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         if (calm_left == 0) begin
            rx_calm = ($urandom_range(0, 4) == 0);
            calm_left = 32;
         end
         calm_left--;
         stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!rsp_ch.valid);
         got = rsp_ch.payload;
         if (replies_due.size() == 0) begin
            mismatches++;
            $display("%0t: expected no beat, got kind=%0d a=%0b b=%0b last=%0b",
                     $time, got.kind, got.place_a_used, got.place_b_used, got.last);
         end else begin
            want = replies_due.pop_front();
            if (got.kind !== want.kind || got.place_a_used !== want.place_a_used ||
                got.place_b_used !== want.place_b_used || got.last !== want.last) begin
               mismatches++;
               $display({"%0t: expected kind=%0d a=%0b b=%0b last=%0b, ",
                         "got kind=%0d a=%0b b=%0b last=%0b"},
                        $time, want.kind, want.place_a_used, want.place_b_used, want.last,
                        got.kind, got.place_a_used, got.place_b_used, got.last);
            end
         end
      end
   end

   initial begin : watchdog
      #5_000_000;
      $display("line_command_receiver_unit: mismatch");
      $finish;
   end

endmodule
